>>> src/tbop_pkg.sv
`timescale 1ns / 1ps

package tbop_pkg;

    // default bank geometry
    localparam int TBOP_NUM_SLOTS   = 16;
    localparam int TBOP_COUNT_WIDTH = 32;

    // command codes
    localparam logic [2:0] CMD_SETUP = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_QUERY = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // slot states
    localparam logic [1:0] SST_CREATED = 2'd0;
    localparam logic [1:0] SST_STARTED = 2'd1;
    localparam logic [1:0] SST_STOPPED = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic exec;
        logic walk;
        logic flush;
    } tbop_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic walk_last;
    } tbop_sts_t;

    // one result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        status;
        logic        fired;
        logic [1:0]  st;
        logic [31:0] dly;
        logic [31:0] per;
        logic        cls;
        logic        last;
    } tbop_res_t;

endpackage

>>> src/tbop_ctrl.sv
`timescale 1ns / 1ps

module tbop_ctrl
    import tbop_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tbop_sts_t sts,
    output tbop_ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = sts.is_tick ? S_WALK : S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                ctl.walk  = 1'b1;
                ctl.rd_en = !sts.walk_last;
                if (sts.walk_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_RD))
        else $error("accepted transaction did not go to read");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && sts.walk_last) |=> (state_reg == S_FLUSH))
        else $error("slot walk did not end in flush");

    a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |=> (state_reg == S_IDLE))
        else $error("flush did not return to idle");

endmodule

>>> src/tbop_dp.sv
`timescale 1ns / 1ps

module tbop_dp
    import tbop_pkg::*;
#(
    parameter int NUM_SLOTS   = TBOP_NUM_SLOTS,
    parameter int COUNT_WIDTH = TBOP_COUNT_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tbop_ctl_t   ctl,
    output tbop_sts_t   sts,
    input  logic [2:0]  cmd,
    input  logic [3:0]  slot,
    input  logic [31:0] first_delay,
    input  logic [31:0] period_ticks,
    input  logic        timer_class,
    output logic        res_valid,
    output tbop_res_t   res
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW     = COUNT_WIDTH;
    localparam logic [6:0] NUM_SLOTS_V = 7'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    typedef struct packed {
        logic [CW-1:0] dly;
        logic [CW-1:0] per;
        logic [CW-1:0] cnt;
        logic          cls;
        logic [1:0]    st;
    } entry_t;

    // captured command
    logic [2:0]     cmd_reg;
    logic [3:0]     slot_reg;
    logic [CW-1:0]  dly_reg;
    logic [CW-1:0]  per_reg;
    logic           cls_reg;

    // slot store with per-entry valid bits
    entry_t         mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_reg;
    entry_t         rd_reg;
    logic           rd_vld_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic           pend_reg;
    logic [3:0]     pend_slot_reg;
    logic [1:0]     pend_st_reg;
    logic           res_valid_reg;
    tbop_res_t      res_reg;

    logic [CW+31:0]     dly_ext;
    logic [CW+31:0]     per_ext;
    logic [SLOT_W+3:0]  slot_ext;
    logic [SLOT_W+3:0]  idx_ext;
    logic [CW+31:0]     cur_dly_ext;
    logic [CW+31:0]     cur_per_ext;
    logic [SLOT_W-1:0]  slot_addr;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  waddr;
    logic               wen;
    entry_t             wdata;
    entry_t             cur;
    entry_t             cmd_new;
    entry_t             walk_new;
    logic               cmd_wen;
    logic [CW-1:0]      cur_load;
    logic [CW-1:0]      cnt_dec;
    logic               in_range;
    logic               match;
    logic               fire_now;
    tbop_res_t          res_cmd;
    tbop_res_t          res_pend;
    tbop_res_t          res_tail;

    assign dly_ext   = {{CW{1'b0}}, first_delay};
    assign per_ext   = {{CW{1'b0}}, period_ticks};
    assign slot_ext  = {{SLOT_W{1'b0}}, slot_reg};
    assign idx_ext   = {4'b0000, idx_reg};
    assign slot_addr = slot_ext[SLOT_W-1:0];
    assign in_range  = ({3'b000, slot_reg} < NUM_SLOTS_V);

    assign sts.is_tick   = (cmd_reg == CMD_TICK);
    assign sts.walk_last = (idx_reg == LAST_IDX);

    // entry that was never written reads as its reset contents
    always_comb
    begin
        if (rd_vld_reg)
        begin
            cur = rd_reg;
        end
        else
        begin
            cur     = '0;
            cur.st  = SST_STOPPED;
        end
    end

    assign cur_load    = (cur.dly != '0) ? cur.dly : cur.per;
    assign cur_dly_ext = {32'd0, cur.dly};
    assign cur_per_ext = {32'd0, cur.per};

    always_comb
    begin
        if (ctl.walk)
        begin
            rd_addr = SLOT_W'(idx_reg + 1'b1);
        end
        else if (sts.is_tick)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = slot_addr;
        end
    end

    // single-slot commands
    always_comb
    begin
        cmd_new        = cur;
        cmd_wen        = 1'b0;
        res_cmd        = '0;
        res_cmd.kind   = KIND_ACK;
        res_cmd.slot   = slot_reg;
        res_cmd.st     = cur.st;
        res_cmd.last   = 1'b1;
        if (cmd_reg > CMD_QUERY || !in_range)
        begin
            res_cmd.status = 1'b1;
            // out-of-bank slot reports the zero state code
            res_cmd.st     = in_range ? cur.st : SST_CREATED;
        end
        else
        begin
            case (cmd_reg)
                CMD_SETUP:
                begin
                    cmd_new.dly = dly_reg;
                    cmd_new.per = per_reg;
                    cmd_new.cnt = (dly_reg != '0) ? dly_reg : per_reg;
                    cmd_new.cls = cls_reg;
                    cmd_new.st  = SST_CREATED;
                    cmd_wen     = 1'b1;
                    res_cmd.st  = SST_CREATED;
                end
                CMD_START:
                begin
                    if (cur.st == SST_CREATED || cur.st == SST_STOPPED)
                    begin
                        cmd_new.cnt = cur_load;
                        cmd_new.st  = SST_STARTED;
                        cmd_wen     = 1'b1;
                        res_cmd.st  = SST_STARTED;
                    end
                    else
                    begin
                        res_cmd.status = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (cur.st == SST_STARTED)
                    begin
                        cmd_new.st = SST_STOPPED;
                        cmd_wen    = 1'b1;
                        res_cmd.st = SST_STOPPED;
                    end
                    else
                    begin
                        res_cmd.status = 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    res_cmd.kind = KIND_QUERY;
                    res_cmd.dly  = cur_dly_ext[31:0];
                    res_cmd.per  = cur_per_ext[31:0];
                    res_cmd.cls  = cur.cls;
                end
                default:
                begin
                    res_cmd.status = 1'b1;
                end
            endcase
        end
    end

    // tick evaluation of the slot under idx_reg
    assign match   = (cur.st == SST_STARTED) && (cur.cls == cls_reg);
    assign cnt_dec = cur.cnt - 1'b1;
    assign fire_now = match && ((cur.cnt == '0) || (cnt_dec == '0));

    always_comb
    begin
        walk_new = cur;
        if (match && cur.cnt != '0)
        begin
            walk_new.cnt = cnt_dec;
        end
        if (fire_now)
        begin
            if (cur.per == '0)
            begin
                walk_new.st = SST_STOPPED;
            end
            else
            begin
                walk_new.cnt = cur.per;
            end
        end
    end

    always_comb
    begin
        res_pend        = '0;
        res_pend.kind   = KIND_FIRE;
        res_pend.slot   = pend_slot_reg;
        res_pend.fired  = 1'b1;
        res_pend.st     = pend_st_reg;
    end

    // final transaction of a tick: the held fire, or a plain acknowledge
    always_comb
    begin
        res_tail      = '0;
        res_tail.kind = KIND_ACK;
        if (pend_reg)
        begin
            res_tail = res_pend;
        end
        res_tail.last = 1'b1;
    end

    assign wen   = (ctl.exec && cmd_wen) || (ctl.walk && match);
    assign waddr = ctl.walk ? idx_reg : slot_addr;
    assign wdata = ctl.walk ? walk_new : cmd_new;

    // slot memory
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_reg     <= mem[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (wen)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (ctl.capture)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (ctl.walk)
            begin
                idx_reg <= SLOT_W'(idx_reg + 1'b1);
                if (fire_now)
                begin
                    pend_reg <= 1'b1;
                end
            end
            else if (ctl.flush)
            begin
                pend_reg <= 1'b0;
            end
            res_valid_reg <= ctl.exec || ctl.flush || (ctl.walk && fire_now && pend_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd;
            slot_reg <= slot;
            dly_reg  <= dly_ext[CW-1:0];
            per_reg  <= per_ext[CW-1:0];
            cls_reg  <= timer_class;
        end
        if (ctl.walk && fire_now)
        begin
            pend_slot_reg <= idx_ext[3:0];
            pend_st_reg   <= walk_new.st;
        end
        if (ctl.exec)
        begin
            res_reg <= res_cmd;
        end
        else if (ctl.flush)
        begin
            res_reg <= res_tail;
        end
        else if (ctl.walk && fire_now && pend_reg)
        begin
            res_reg <= res_pend;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.flush |=> !pend_reg)
        else $error("pending fire left after flush");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.last) |=> !res_valid_reg)
        else $error("result directly after final result");

    a_fire_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.walk && fire_now && pend_reg) |=> (res_valid_reg && res_reg.kind == KIND_FIRE
            && !res_reg.last))
        else $error("fire transaction not emitted");

endmodule

>>> src/timer_bank_oneshot_periodic_top.sv
// a set up, start, stop or query result is registered in the execute state after the store
//   read; a tick's fires follow in slot order, the final one registered in the flush state
// a new command is taken only back in idle, with busy high meanwhile; a tick walks the
//   one-read one-write slot store one slot per cycle
// reset: asynchronous, active low; every slot reads stopped with zero settings at once
// results are strobed for one cycle each; the receiver cannot stall
`timescale 1ns / 1ps

module timer_bank_oneshot_periodic_top
    import tbop_pkg::*;
#(
    parameter int NUM_SLOTS   = TBOP_NUM_SLOTS,
    parameter int COUNT_WIDTH = TBOP_COUNT_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command transaction
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [3:0]  slot,
    input  logic [31:0] first_delay,
    input  logic [31:0] period_ticks,
    input  logic        timer_class,
    // result transaction
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [3:0]  slot_out,
    output logic        status,
    output logic        any_fired,
    output logic [1:0]  state_out,
    output logic [31:0] delay_out,
    output logic [31:0] period_out,
    output logic        class_out,
    output logic        last
);

    tbop_ctl_t ctl;
    tbop_sts_t sts;
    tbop_res_t res;

    // sequencer: idle, store read, single command execute or slot walk, flush
    tbop_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // slot store, countdown update and result register
    tbop_dp #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .slot         (slot),
        .first_delay  (first_delay),
        .period_ticks (period_ticks),
        .timer_class  (timer_class),
        .res_valid    (result_valid),
        .res          (res)
    );

    // result fields straight from the output register
    assign kind       = res.kind;
    assign slot_out   = res.slot;
    assign status     = res.status;
    assign any_fired  = res.fired;
    assign state_out  = res.st;
    assign delay_out  = res.dly;
    assign period_out = res.per;
    assign class_out  = res.cls;
    assign last       = res.last;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tbop_pkg::*;

    localparam int SLOTS        = TBOP_NUM_SLOTS;
    localparam int RANDOM_CMDS  = 205;
    // far above the slowest gap between two accepted transactions (a full slot walk)
    localparam int STALL_LIMIT  = 2000;
    // a tick's final fire trails the walk through the flush state; give the tail plenty of room
    localparam int DRAIN_CYCLES = 40;
    // command codes above query are undefined and must come back rejected
    localparam logic [2:0] CMD_BAD_LO  = 3'd5;
    localparam logic [2:0] CMD_BAD_MID = 3'd6;
    localparam logic [2:0] CMD_BAD_HI  = 3'd7;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    // one command transaction plus an optional hand-written expectation
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        logic [31:0] dly;
        logic [31:0] per;
        logic        cls;
        logic        typed;
        tbop_res_t   want;
    } timer_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] first_delay;
    logic [31:0] period_ticks;
    logic        timer_class;
    logic        result_valid;
    logic [1:0]  kind;
    logic [3:0]  slot_out;
    logic        status;
    logic        any_fired;
    logic [1:0]  state_out;
    logic [31:0] delay_out;
    logic [31:0] period_out;
    logic        class_out;
    logic        last;

    // own copy of the slot bank, advanced once per accepted command
    logic [31:0] bank_delay  [SLOTS];
    logic [31:0] bank_period [SLOTS];
    logic [31:0] bank_count  [SLOTS];
    logic        bank_class  [SLOTS];
    logic [1:0]  bank_state  [SLOTS];

    timer_cmd_t  command_list [$];
    tbop_res_t   pending_timer_results [$];
    tbop_res_t   arrived;
    int          directed_rows;
    int          cmd_index;
    int          error_count;
    int          result_count;
    int          fire_count;
    int          fires_this_tick;
    int          widest_tick;
    int          stall_cycles;

    timer_bank_oneshot_periodic_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .slot         (slot),
        .first_delay  (first_delay),
        .period_ticks (period_ticks),
        .timer_class  (timer_class),
        .result_valid (result_valid),
        .kind         (kind),
        .slot_out     (slot_out),
        .status       (status),
        .any_fired    (any_fired),
        .state_out    (state_out),
        .delay_out    (delay_out),
        .period_out   (period_out),
        .class_out    (class_out),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // single-result expectation for the directed rows, always the last of its command
    function automatic tbop_res_t one_result(logic [1:0] k, logic [3:0] s, logic sts,
                                             logic [1:0] st, logic [31:0] d,
                                             logic [31:0] p, logic c);
        tbop_res_t r;
        r        = '0;
        r.kind   = k;
        r.slot   = s;
        r.status = sts;
        r.st     = st;
        r.dly    = d;
        r.per    = p;
        r.cls    = c;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic add_cmd(logic [2:0] c, logic [3:0] s, logic [31:0] d, logic [31:0] p,
                           logic k, logic typed, tbop_res_t want);
        timer_cmd_t t;
        t       = '0;
        t.cmd   = c;
        t.slot  = s;
        t.dly   = d;
        t.per   = p;
        t.cls   = k;
        t.typed = typed;
        t.want  = want;
        command_list.push_back(t);
    endtask

    // after reset every slot is stopped with zero settings
    task automatic clear_bank_model();
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            bank_delay[i]  = '0;
            bank_period[i] = '0;
            bank_count[i]  = '0;
            bank_class[i]  = 1'b0;
            bank_state[i]  = SST_STOPPED;
        end
    endtask

    // works out every result one command causes and queues them in order
    task automatic predict_timer_results(timer_cmd_t t);
        tbop_res_t batch [$];
        tbop_res_t r;
        int        i;
        logic      hit;
        batch.delete();
        if (t.cmd == CMD_TICK)
        begin
            // walk in slot order; only started slots of the ticked class count down
            for (i = 0; i < SLOTS; i++)
            begin
                if (bank_state[i] == SST_STARTED && bank_class[i] == t.cls)
                begin
                    if (bank_count[i] == '0)
                        hit = 1'b1;
                    else
                    begin
                        bank_count[i] = bank_count[i] - 32'd1;
                        hit = (bank_count[i] == '0);
                    end
                    if (hit)
                    begin
                        // one-shot stops, periodic reloads its period
                        if (bank_period[i] == '0)
                            bank_state[i] = SST_STOPPED;
                        else
                            bank_count[i] = bank_period[i];
                        r       = '0;
                        r.kind  = KIND_FIRE;
                        r.slot  = 4'(i);
                        r.fired = 1'b1;
                        r.st    = bank_state[i];
                        batch.push_back(r);
                    end
                end
            end
            if (batch.size() == 0)
            begin
                r      = '0;
                r.kind = KIND_ACK;
                batch.push_back(r);
            end
        end
        else
        begin
            r      = '0;
            r.slot = t.slot;
            r.kind = KIND_ACK;
            case (t.cmd)
                CMD_SETUP:
                begin
                    // always taken; countdown loads the delay, or the period when delay is zero
                    bank_delay[t.slot]  = t.dly;
                    bank_period[t.slot] = t.per;
                    bank_class[t.slot]  = t.cls;
                    bank_count[t.slot]  = (t.dly != '0) ? t.dly : t.per;
                    bank_state[t.slot]  = SST_CREATED;
                end
                CMD_START:
                begin
                    if (bank_state[t.slot] == SST_STARTED)
                        r.status = 1'b1;
                    else
                    begin
                        bank_count[t.slot] = (bank_delay[t.slot] != '0) ?
                                             bank_delay[t.slot] : bank_period[t.slot];
                        bank_state[t.slot] = SST_STARTED;
                    end
                end
                CMD_STOP:
                begin
                    if (bank_state[t.slot] == SST_STARTED)
                        bank_state[t.slot] = SST_STOPPED;
                    else
                        r.status = 1'b1;
                end
                CMD_QUERY:
                begin
                    r.kind = KIND_QUERY;
                    r.dly  = bank_delay[t.slot];
                    r.per  = bank_period[t.slot];
                    r.cls  = bank_class[t.slot];
                end
                default:
                    // undefined code: rejected, nothing changes
                    r.status = 1'b1;
            endcase
            r.st = bank_state[t.slot];
            batch.push_back(r);
        end
        batch[batch.size() - 1].last = 1'b1;
        // hand-written rows replace the computed answer; the bank copy still advances
        if (t.typed)
        begin
            batch.delete();
            batch.push_back(t.want);
        end
        foreach (batch[i])
            pending_timer_results.push_back(batch[i]);
    endtask

    // directed rows: reset state, code extremes, rejections, zero countdown, one-shot
    // and periodic firing, two fires on one tick
    task automatic build_directed_rows();
        add_cmd(CMD_QUERY, 4'd0, 0, 0, 1'b0, 1'b1,
                one_result(KIND_QUERY, 4'd0, 1'b0, SST_STOPPED, 0, 0, 1'b0));
        add_cmd(CMD_STOP, 4'd3, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd3, 1'b1, SST_STOPPED, 0, 0, 1'b0));
        add_cmd(CMD_TICK, 4'd0, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd0, 1'b0, SST_CREATED, 0, 0, 1'b0));
        add_cmd(CMD_TICK, 4'd0, 0, 0, 1'b1, 1'b1,
                one_result(KIND_ACK, 4'd0, 1'b0, SST_CREATED, 0, 0, 1'b0));
        add_cmd(CMD_BAD_LO, 4'd7, ALL_ONES, ALL_ONES, 1'b1, 1'b1,
                one_result(KIND_ACK, 4'd7, 1'b1, SST_STOPPED, 0, 0, 1'b0));
        add_cmd(CMD_BAD_HI, 4'd15, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd15, 1'b1, SST_STOPPED, 0, 0, 1'b0));
        add_cmd(CMD_BAD_MID, 4'd9, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd9, 1'b1, SST_STOPPED, 0, 0, 1'b0));
        add_cmd(CMD_SETUP, 4'd15, ALL_ONES, ALL_ONES, 1'b1, 1'b1,
                one_result(KIND_ACK, 4'd15, 1'b0, SST_CREATED, 0, 0, 1'b0));
        add_cmd(CMD_QUERY, 4'd15, 0, 0, 1'b0, 1'b1,
                one_result(KIND_QUERY, 4'd15, 1'b0, SST_CREATED, ALL_ONES, ALL_ONES, 1'b1));
        add_cmd(CMD_STOP, 4'd15, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd15, 1'b1, SST_CREATED, 0, 0, 1'b0));
        add_cmd(CMD_START, 4'd15, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd15, 1'b0, SST_STARTED, 0, 0, 1'b0));
        add_cmd(CMD_START, 4'd15, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd15, 1'b1, SST_STARTED, 0, 0, 1'b0));
        // countdown at its top value only drops by one
        add_cmd(CMD_TICK, 4'd0, 0, 0, 1'b1, 1'b1,
                one_result(KIND_ACK, 4'd0, 1'b0, SST_CREATED, 0, 0, 1'b0));
        add_cmd(CMD_STOP, 4'd15, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd15, 1'b0, SST_STOPPED, 0, 0, 1'b0));
        add_cmd(CMD_SETUP, 4'd0, 0, 0, 1'b0, 1'b1,
                one_result(KIND_ACK, 4'd0, 1'b0, SST_CREATED, 0, 0, 1'b0));
        // zero delay and zero period: fires on the very first tick, then stops
        add_cmd(CMD_START, 4'd0, 0, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_TICK,  4'd0, 0, 0, 1'b0, 1'b0, '0);
        // one-shot after two ticks, periodic every tick through a zero delay
        add_cmd(CMD_SETUP, 4'd1, 32'd2, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_SETUP, 4'd2, 0, 32'd1, 1'b0, 1'b0, '0);
        add_cmd(CMD_START, 4'd1, 0, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_START, 4'd2, 0, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_TICK,  4'd0, 0, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_TICK,  4'd0, 0, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_QUERY, 4'd2, 0, 0, 1'b0, 1'b0, '0);
        add_cmd(CMD_QUERY, 4'd1, 0, 0, 1'b0, 1'b0, '0);
        directed_rows = command_list.size();
    endtask

    // every slot armed with delay one on one class, so the first tick fires all of them
    task automatic add_full_burst();
        int   s;
        logic c;
        c = 1'($urandom_range(0, 1));
        for (s = 0; s < SLOTS; s++)
            add_cmd(CMD_SETUP, 4'(s), 32'd1, 32'($urandom_range(1, 3)), c, 1'b0, '0);
        for (s = 0; s < SLOTS; s++)
            add_cmd(CMD_START, 4'(s), $urandom, $urandom, 1'($urandom_range(0, 1)),
                    1'b0, '0);
        repeat ($urandom_range(2, 4))
            add_cmd(CMD_TICK, 4'($urandom_range(0, 15)), $urandom, $urandom, c, 1'b0, '0);
    endtask

    // mostly set up / start / tick with small counts so slots really fire,
    // with stops, queries, full-range values and undefined codes mixed in
    task automatic build_random_rows();
        int          base;
        int          pick;
        logic [31:0] d;
        logic [31:0] p;
        base = command_list.size();
        add_full_burst();
        while (command_list.size() - base < RANDOM_CMDS)
        begin
            pick = $urandom_range(0, 99);
            d    = $urandom;
            p    = $urandom;
            if (pick < 3)
                add_full_burst();
            else if (pick < 28)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    d = $urandom_range(0, 4);
                    p = $urandom_range(0, 4);
                end
                add_cmd(CMD_SETUP, 4'($urandom_range(0, 15)), d, p,
                        1'($urandom_range(0, 1)), 1'b0, '0);
            end
            else if (pick < 50)
                add_cmd(CMD_START, 4'($urandom_range(0, 15)), d, p,
                        1'($urandom_range(0, 1)), 1'b0, '0);
            else if (pick < 60)
                add_cmd(CMD_STOP, 4'($urandom_range(0, 15)), d, p,
                        1'($urandom_range(0, 1)), 1'b0, '0);
            else if (pick < 85)
                add_cmd(CMD_TICK, 4'($urandom_range(0, 15)), d, p,
                        1'($urandom_range(0, 1)), 1'b0, '0);
            else if (pick < 95)
                add_cmd(CMD_QUERY, 4'($urandom_range(0, 15)), d, p,
                        1'($urandom_range(0, 1)), 1'b0, '0);
            else
                add_cmd(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)),
                        4'($urandom_range(0, 15)), d, p, 1'($urandom_range(0, 1)),
                        1'b0, '0);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: result %s mismatch, expected %0h actual %0h", $time, name,
                     want, got);
            error_count++;
        end
    endtask

    // result side: one strobe per result, no back-pressure possible
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            result_count++;
            if (pending_timer_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, kind %0h slot %0h", $time,
                         kind, slot_out);
                error_count++;
            end
            else
            begin
                arrived = pending_timer_results.pop_front();
                check_field("kind",       arrived.kind,   kind);
                check_field("slot_out",   arrived.slot,   slot_out);
                check_field("status",     arrived.status, status);
                check_field("any_fired",  arrived.fired,  any_fired);
                check_field("state_out",  arrived.st,     state_out);
                check_field("delay_out",  arrived.dly,    delay_out);
                check_field("period_out", arrived.per,    period_out);
                check_field("class_out",  arrived.cls,    class_out);
                check_field("last",       arrived.last,   last);
            end
            // track the widest burst of fires from a single tick
            if (any_fired === 1'b1)
            begin
                fire_count++;
                fires_this_tick++;
            end
            if (last === 1'b1)
            begin
                if (fires_this_tick > widest_tick)
                    widest_tick = fires_this_tick;
                fires_this_tick = 0;
            end
        end
    end

    // watchdog: ends the run when nothing is accepted on either side for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || (rst_n && result_valid))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // command side: walk the table, predict at each accepted edge
    initial
    begin
        logic pause;
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = CMD_SETUP;
        slot            = '0;
        first_delay     = '0;
        period_ticks    = '0;
        timer_class     = 1'b0;
        error_count     = 0;
        result_count    = 0;
        fire_count      = 0;
        fires_this_tick = 0;
        widest_tick     = 0;
        clear_bank_model();
        build_directed_rows();
        build_random_rows();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        cmd_index = 0;
        while (cmd_index < command_list.size())
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                predict_timer_results(command_list[cmd_index]);
                cmd_index++;
            end
            // a transaction held against busy stays put; otherwise offer the next one
            if (!(start && busy))
            begin
                // a stretch in the middle runs back to back with no gaps
                pause = (cmd_index < 90 || cmd_index >= 160) && ($urandom_range(0, 99) < 9);
                if (cmd_index < command_list.size() && !pause)
                begin
                    cmd          <= command_list[cmd_index].cmd;
                    slot         <= command_list[cmd_index].slot;
                    first_delay  <= command_list[cmd_index].dly;
                    period_ticks <= command_list[cmd_index].per;
                    timer_class  <= command_list[cmd_index].cls;
                    start        <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end

        // drain, then let any straggler show up before judging
        while (pending_timer_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d commands (%0d directed rows), %0d results checked",
                 command_list.size(), directed_rows, result_count);
        $display("summary: %0d fire events, up to %0d from one tick", fire_count,
                 widest_tick);
        if (error_count == 0 && pending_timer_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> timer_bank_oneshot_periodic_top.f
src/tbop_pkg.sv
src/tbop_ctrl.sv
src/tbop_dp.sv
src/timer_bank_oneshot_periodic_top.sv
bench/testbench.sv
